FILE: rtl/strf_pkg.sv
package strf_pkg;

    localparam int RING_SLOTS = 128;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int LEN_W      = (SLOT_W + 1 > 8) ? SLOT_W + 1 : 8;
    localparam int COUNT_W    = 7;
    localparam int SEQ_W      = 31;
    localparam int MAXREC_W   = 7;
    localparam int RECBYTES_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int HEADER_BYTES = 12;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PURGE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]       op;
        logic [63:0]      payload;
        logic [15:0]      record_size;
        logic [31:0]      time_now;
        logic [SEQ_W-1:0] purge_seq;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SEQ_W-1:0]   seq;
        logic [63:0]        out_payload;
        logic [15:0]        out_size;
        logic [31:0]        out_time;
        logic               out_oversize;
        logic [COUNT_W-1:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [31:0]      time_now;
        logic [15:0]      size;
        logic             oversize;
        logic [63:0]      payload;
    } slot_rec_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

FILE: rtl/seq_tagged_record_fifo_unit.sv
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | in_word (op, payload, size, time, purge seq)
// out      | output    | out_valid / out_stall | out_word (status, seq, head record, count)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
// each word is accepted with a head slot read, then executed
// the head slot is read from the single-port slot memory on accept
// the next word is accepted while a result still waits in the output register
// rst_n clears pointers and sequence counter and resets config to defaults; slot memory is not cleared
// a stalled output holds execution of the next word until it is taken
module seq_tagged_record_fifo_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  strf_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output strf_pkg::out_word_t             out_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [strf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [strf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import strf_pkg::*;

    ctl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    strf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    strf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word)
    );

endmodule

FILE: rtl/strf_ctrl.sv
module strf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output strf_pkg::ctl_cmd_t cmd
);
    import strf_pkg::*;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.execute    = (state_reg == ST_EXEC) && out_free;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter execution");

    a_exec_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("execution did not produce a result");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without execution");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");

endmodule

FILE: rtl/strf_datapath.sv
module strf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  strf_pkg::ctl_cmd_t                  cmd,
    input  strf_pkg::in_word_t                  in_word,
    input  logic                                cfg_we,
    input  logic [strf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [strf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output strf_pkg::out_word_t                 out_word
);
    import strf_pkg::*;

    slot_rec_t mem [RING_SLOTS];

    logic [MAXREC_W-1:0]   max_records_reg;
    logic [RECBYTES_W-1:0] record_bytes_reg;
    logic [SLOT_W-1:0]     head_reg;
    logic [SLOT_W-1:0]     head_next;
    logic [SLOT_W-1:0]     tail_reg;
    logic [SLOT_W-1:0]     tail_next;
    logic [SEQ_W-1:0]      last_seq_reg;
    logic [SEQ_W-1:0]      last_seq_next;
    in_word_t              in_reg;
    slot_rec_t             rd_reg;
    out_word_t             out_reg;
    out_word_t             out_next;

    logic [MAXREC_W-1:0]   mr_eff;
    logic [LEN_W-1:0]      n_raw;
    logic [LEN_W-1:0]      ring_len;
    logic [SLOT_W-1:0]     tail_adv;
    logic [SLOT_W-1:0]     head_adv;
    logic [SEQ_W-1:0]      seq_inc;
    logic                  empty;
    logic                  full;
    logic                  do_write;
    logic [16:0]           size_plus_hdr;
    slot_rec_t             wr_rec;
    logic [LEN_W:0]        cnt_wide;
    logic [COUNT_W-1:0]    cnt_sat;

    function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] p,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] p1;
        begin
            p1 = LEN_W'(p) + LEN_W'(1);
            advance = (p1 >= len) ? '0 : p1[SLOT_W-1:0];
        end
    endfunction

    // slot count of the ring, capped at storage
    assign mr_eff   = (max_records_reg == '0) ? MAXREC_W'(1) : max_records_reg;
    assign n_raw    = LEN_W'(mr_eff) + LEN_W'(1);
    assign ring_len = (n_raw > LEN_W'(RING_SLOTS)) ? LEN_W'(RING_SLOTS) : n_raw;

    assign tail_adv = advance(tail_reg, ring_len);
    assign head_adv = advance(head_reg, ring_len);
    assign empty    = (head_reg == tail_reg);
    assign full     = (tail_adv == head_reg);
    assign seq_inc  = (last_seq_reg == '1) ? SEQ_W'(1) : last_seq_reg + SEQ_W'(1);
    assign do_write = cmd.execute && (in_reg.op == OP_WRITE) && !full;

    assign size_plus_hdr   = {1'b0, in_reg.record_size} + 17'(HEADER_BYTES);
    assign wr_rec.seq      = seq_inc;
    assign wr_rec.time_now = in_reg.time_now;
    assign wr_rec.size     = in_reg.record_size;
    assign wr_rec.oversize = (size_plus_hdr > 17'(record_bytes_reg));
    assign wr_rec.payload  = in_reg.payload;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        last_seq_next = last_seq_reg;
        out_next      = '0;
        case (in_reg.op)
            OP_WRITE:
            begin
                if (full)
                begin
                    out_next.status = ST_FULL;
                end
                else
                begin
                    tail_next     = tail_adv;
                    last_seq_next = seq_inc;
                    out_next.seq  = seq_inc;
                end
            end
            OP_READ:
            begin
                if (empty)
                begin
                    out_next.status = ST_EMPTY;
                end
                else
                begin
                    out_next.seq          = rd_reg.seq;
                    out_next.out_payload  = rd_reg.payload;
                    out_next.out_size     = rd_reg.size;
                    out_next.out_time     = rd_reg.time_now;
                    out_next.out_oversize = rd_reg.oversize;
                end
            end
            OP_PURGE:
            begin
                if (empty)
                begin
                    out_next.status = ST_EMPTY;
                end
                else if (rd_reg.seq != in_reg.purge_seq)
                begin
                    out_next.status = ST_MISMATCH;
                end
                else
                begin
                    head_next = head_adv;
                end
            end
            OP_CLEAR:
            begin
                head_next     = '0;
                tail_next     = '0;
                last_seq_next = '0;
            end
            default:
            begin
                out_next.status = ST_OK;
            end
        endcase

        // count after the operation, saturated
        if (tail_next >= head_next)
        begin
            cnt_wide = (LEN_W + 1)'(tail_next) - (LEN_W + 1)'(head_next);
        end
        else if ((LEN_W + 1)'(ring_len) + (LEN_W + 1)'(tail_next) >= (LEN_W + 1)'(head_next))
        begin
            cnt_wide = (LEN_W + 1)'(ring_len) - (LEN_W + 1)'(head_next)
                     + (LEN_W + 1)'(tail_next);
        end
        else
        begin
            cnt_wide = '0;
        end
        cnt_sat = (cnt_wide > (LEN_W + 1)'(127)) ? COUNT_W'(127) : cnt_wide[COUNT_W-1:0];
        out_next.entry_count = cnt_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_records_reg  <= MAXREC_W'(127);
            record_bytes_reg <= RECBYTES_W'(64);
            head_reg         <= '0;
            tail_reg         <= '0;
            last_seq_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MAX_RECORDS)
            begin
                max_records_reg <= cfg_data[MAXREC_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_RECORD_BYTES)
            begin
                record_bytes_reg <= cfg_data[RECBYTES_W-1:0];
            end
            if (cmd.execute)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                last_seq_reg <= last_seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_word;
            rd_reg <= mem[head_reg];
        end
        if (cmd.execute)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[tail_reg] <= wr_rec;
        end
    end

    assign out_word = out_reg;

endmodule
